@@ rtl/tis_pkg.sv @@
package tis_pkg;

	// fixed field widths of the stream payloads
	localparam int SYM_W      = 5;
	localparam int STATUS_W   = 2;
	localparam int MLEN_W     = 8;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 16;

	// request kinds carried on tuser
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// one result transaction as held in the output register
	typedef struct packed {
		logic              is_word;
		logic [MLEN_W-1:0] match_length;
		status_t           status;
		logic              op_echo;
	} result_t;

endpackage

@@ rtl/trie_insert_search.sv @@
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  tdata: symbol; tuser: req_type; tlast: last_symbol
// m        out  m_tvalid/m_tready  tdata: status, match_length, is_word; tuser: op_echo
//
// each symbol is taken with a child-table read, then in the walk state the
// walk is updated and the entry is written back
// a final symbol waits in the walk state while the previous result is untaken
// after reset a clearing pass zeroes all NODE_COUNT*ALPHABET_SIZE entries
// (26624 by default) of the child table; no transaction is taken until it ends
// reset is asynchronous, active low, and returns the walk to the root
module trie_insert_search #(
	parameter int NODE_COUNT     = 1024,
	parameter int ALPHABET_SIZE  = 26,
	parameter int MAX_KEY_LENGTH = 255
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tis_pkg::IN_DATA_W-1:0]    s_tdata,  // [4:0] symbol, rest zero
	input  logic                             s_tuser,  // [0] req_type
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tis_pkg::OUT_DATA_W-1:0]   m_tdata,  // [1:0] status, [9:2] match_length,
	                                                   // [10] is_word, rest zero
	output logic                             m_tuser   // [0] op_echo
);

	localparam int TABLE_DEPTH = NODE_COUNT * ALPHABET_SIZE;
	localparam int AW          = $clog2(TABLE_DEPTH);
	localparam int NW          = $clog2(NODE_COUNT);
	localparam int UW          = $clog2(NODE_COUNT + 1);
	localparam int SEEN_W      = $clog2(MAX_KEY_LENGTH + 1);
	localparam int EW          = NW + 1;  // child index and its word-end mark

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic state_q;

	// walk state
	logic [NW-1:0]     cur_node_q;
	logic [AW-1:0]     par_addr_q;   // slot that points at cur_node_q
	logic [SEEN_W-1:0] seen_q;
	logic              miss_q;
	logic              full_q;
	logic [UW-1:0]     nodes_used_q;

	// item in flight
	logic          req_s1;
	logic          last_s1;
	logic          inr_s1;
	logic [AW-1:0] addr_s1;

	// output register
	logic                m_valid_q;
	tis_pkg::result_t    res_q;

	// clearing pass
	logic          clr_busy;
	logic [AW-1:0] clr_addr;

	// memory ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [EW-1:0] mem_rdata;

	logic          accept;
	logic          step;
	logic          stall;
	logic [AW-1:0] slot_addr;
	logic          sym_inr;

	logic [NW-1:0]     rd_child;
	logic              rd_word;
	logic              hit;
	logic              flags_clear;
	logic              ins;
	logic              do_walk;
	logic              pool_full;
	logic              alloc;
	logic              full_set;
	logic              miss_set;
	logic              advance;
	logic              miss_n;
	logic              full_n;
	logic              mark;
	logic              srch_ok;
	logic [NW-1:0]     next_node;
	logic [SEEN_W-1:0] seen_n;
	logic              walk_we;
	logic [AW-1:0]     walk_waddr;
	logic [EW-1:0]     walk_wdata;
	tis_pkg::result_t  res_n;

	tis_clear #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (clr_busy),
		.addr   (clr_addr)
	);

	tis_mem #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (EW),
		.AW    (AW)
	) u_child_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// ---- first cycle: slot address and read ----
	assign s_tready  = (state_q == ST_IDLE) && !clr_busy;
	assign accept    = s_tvalid && s_tready;
	assign sym_inr   = 32'(s_tdata[tis_pkg::SYM_W-1:0]) < 32'(ALPHABET_SIZE);
	assign slot_addr = AW'(AW'(cur_node_q) * AW'(ALPHABET_SIZE))
	                 + AW'(s_tdata[tis_pkg::SYM_W-1:0]);
	assign mem_re    = accept;
	assign mem_raddr = slot_addr;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= s_tuser;
			last_s1 <= s_tlast;
			inr_s1  <= sym_inr;
			addr_s1 <= slot_addr;
		end
	end

	// ---- second cycle: follow or allocate, write back ----
	assign rd_child    = mem_rdata[EW-1:1];
	assign rd_word     = mem_rdata[0];
	assign hit         = rd_child != '0;
	assign flags_clear = !miss_q && !full_q;
	assign ins         = req_s1 == tis_pkg::REQ_INSERT;
	assign do_walk     = flags_clear && inr_s1;
	assign pool_full   = nodes_used_q == UW'(NODE_COUNT);
	assign alloc       = do_walk && ins && !hit && !pool_full;
	assign full_set    = do_walk && ins && !hit && pool_full;
	// an out-of-range symbol in a search counts as a missing link
	assign miss_set    = flags_clear && !ins && (!inr_s1 || !hit);
	assign advance     = do_walk && (hit || alloc);
	assign next_node   = hit ? rd_child : nodes_used_q[NW-1:0];
	assign miss_n      = miss_q || miss_set;
	assign full_n      = full_q || full_set;
	assign mark        = last_s1 && ins && !miss_n && !full_n;
	assign seen_n      = (advance && (seen_q != SEEN_W'(MAX_KEY_LENGTH))) ?
	                     seen_q + 1'b1 : seen_q;

	assign stall = last_s1 && m_valid_q && !m_tready;
	assign step  = (state_q == ST_WALK) && !stall;

	// word-end marks live beside the link in the parent slot; a node has one parent
	always_comb begin
		walk_we    = 1'b0;
		walk_waddr = addr_s1;
		walk_wdata = {next_node, mark || (hit && rd_word)};
		if (advance && ins && (alloc || mark)) begin
			walk_we = step;
		end else if (mark && !advance && (cur_node_q != '0)) begin
			// insert ending on an ignored symbol marks the node already reached, unless it is the root
			walk_we    = step;
			walk_waddr = par_addr_q;
			walk_wdata = {cur_node_q, 1'b1};
		end
	end

	assign mem_we    = clr_busy || walk_we;
	assign mem_waddr = clr_busy ? clr_addr : walk_waddr;
	assign mem_wdata = clr_busy ? '0 : walk_wdata;

	// result of a final item
	assign srch_ok = !ins && !miss_n && !full_n;
	always_comb begin
		res_n.op_echo      = req_s1;
		res_n.match_length = '0;
		res_n.is_word      = 1'b0;
		priority if (miss_n) begin
			res_n.status = tis_pkg::ST_MISS;
		end else if (full_n) begin
			res_n.status = tis_pkg::ST_FULL;
		end else begin
			res_n.status = tis_pkg::ST_OK;
		end
		if (srch_ok) begin
			res_n.match_length = (32'(seen_n) > 32'd255) ? 8'hFF : 8'(seen_n);
			res_n.is_word      = rd_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (step) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_node_q   <= '0;
			par_addr_q   <= '0;
			seen_q       <= '0;
			miss_q       <= 1'b0;
			full_q       <= 1'b0;
			nodes_used_q <= UW'(1);
		end else if (step) begin
			if (alloc) begin
				nodes_used_q <= nodes_used_q + 1'b1;
			end
			if (last_s1) begin
				// every word ends back at the root with clean flags
				cur_node_q <= '0;
				seen_q     <= '0;
				miss_q     <= 1'b0;
				full_q     <= 1'b0;
			end else begin
				if (advance) begin
					cur_node_q <= next_node;
					par_addr_q <= addr_s1;
				end
				seen_q <= seen_n;
				miss_q <= miss_n;
				full_q <= full_n;
			end
		end
	end

	// output register, refilled in the same cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			res_q <= res_n;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_q.op_echo;
	assign m_tdata  = {5'b0, res_q.is_word, res_q.match_length, res_q.status};

	// the walk never writes the table in a cycle that also reads it
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !walk_we)
		else $error("child table written during a read");

	// the pool only grows, and never past its size
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(nodes_used_q <= UW'(NODE_COUNT)) && (nodes_used_q >= $past(nodes_used_q)))
		else $error("node pool count out of bounds");

	// a word is either skipped as missing or as full, never both
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(miss_q && full_q))
		else $error("miss and full flags both set");

	// a node below the root is only reached by counting a symbol
	a_depth_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_node_q != '0) |-> (seen_q != '0))
		else $error("walk below root with no symbols counted");

	// a final symbol that finishes its walk always leaves a result
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_s1) |=> m_valid_q)
		else $error("final symbol produced no result");

endmodule

@@ rtl/tis_mem.sv @@
module tis_mem #(
	parameter int DEPTH = 26624,
	parameter int WIDTH = 11,
	parameter int AW    = 15
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/tis_clear.sv @@
module tis_clear #(
	parameter int DEPTH = 26624,
	parameter int AW    = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	output logic          busy,
	output logic [AW-1:0] addr
);

	logic [AW-1:0] cnt_q;
	logic          busy_q;

	// one entry per cycle from the bottom up, then idle for good
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (cnt_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign busy = busy_q;
	assign addr = cnt_q;

endmodule

@@ test/trie_insert_search_test.sv @@
module trie_insert_search_test;

	// block sizes at their default values
	localparam int NODES       = 1024;
	localparam int LETTERS     = 26;
	localparam int KEY_CAP     = 255;
	localparam int ITEM_TARGET = 1450;
	// no transaction for this many cycles ends the run; well above the clearing pass
	localparam int STALL_LIMIT = 120000;
	localparam int DICT_SIZE   = 128;
	localparam int DICT_WORD   = 16;
	localparam int KEY_MAX     = 320;

	// one finished word as it should leave the block
	typedef struct {
		logic             op;
		tis_pkg::status_t status;
		logic [7:0]       mlen;
		logic             word;
	} lookup_outcome_t;

	// mirror of the trie: walks every accepted symbol and queues the outcomes due
	class trie_shadow;
		int unsigned     child_of [NODES*LETTERS];
		bit              word_end [NODES];
		int unsigned     nodes_used;
		int unsigned     cur_node;
		int unsigned     seen;
		bit              missed;
		bit              full;
		lookup_outcome_t due[$];
		int              mismatches;

		function new();
			nodes_used = 1;
			cur_node   = 0;
			seen       = 0;
			missed     = 0;
			full       = 0;
			mismatches = 0;
		endfunction

		function int due_count();
			return due.size();
		endfunction

		function void note_symbol(logic req, logic [4:0] sym, logic last);
			int unsigned     slot;
			lookup_outcome_t got;
			if (!missed && !full) begin
				if (req == tis_pkg::REQ_INSERT) begin
					// letters past the alphabet are dropped by an insert
					if (sym < LETTERS) begin
						slot = cur_node * LETTERS + sym;
						if (child_of[slot] == 0) begin
							if (nodes_used >= NODES) begin
								full = 1'b1;
							end else begin
								child_of[slot] = nodes_used;
								nodes_used++;
							end
						end
						if (!full) begin
							cur_node = child_of[slot];
							if (seen < KEY_CAP) seen++;
						end
					end
				end else begin
					if (sym >= LETTERS) begin
						missed = 1'b1;
					end else begin
						slot = cur_node * LETTERS + sym;
						if (child_of[slot] == 0) begin
							missed = 1'b1;
						end else begin
							cur_node = child_of[slot];
							if (seen < KEY_CAP) seen++;
						end
					end
				end
			end
			if (last) begin
				got.op   = req;
				got.mlen = '0;
				got.word = 1'b0;
				if (missed) begin
					got.status = tis_pkg::ST_MISS;
				end else if (full) begin
					got.status = tis_pkg::ST_FULL;
				end else begin
					got.status = tis_pkg::ST_OK;
					if (req == tis_pkg::REQ_INSERT) begin
						word_end[cur_node] = 1'b1;
					end else begin
						got.mlen = 8'(seen);
						got.word = word_end[cur_node];
					end
				end
				due.push_back(got);
				cur_node = 0;
				seen     = 0;
				missed   = 1'b0;
				full     = 1'b0;
			end
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			mismatches++;
			$display("mismatch in %s: got %0h, want %0h at %0t", what, got, want, $realtime);
		endtask

		task check_outcome(logic op, logic [tis_pkg::OUT_DATA_W-1:0] data);
			lookup_outcome_t want;
			if (due.size() == 0) begin
				report_mismatch("result with nothing due", data, 0);
				return;
			end
			want = due.pop_front();
			if (op !== want.op) report_mismatch("op_echo", op, want.op);
			if (data[1:0] !== want.status) report_mismatch("status", data[1:0], want.status);
			if (data[9:2] !== want.mlen) report_mismatch("match_length", data[9:2], want.mlen);
			if (data[10] !== want.word) report_mismatch("is_word", data[10], want.word);
			if (data[15:11] !== 5'd0) report_mismatch("tdata padding", data[15:11], 0);
		endtask
	endclass

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [tis_pkg::IN_DATA_W-1:0]  s_tdata  = '0;  // [4:0] symbol, rest zero
	logic                           s_tuser  = 1'b0; // [0] req_type
	logic                           s_tlast  = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [tis_pkg::OUT_DATA_W-1:0] m_tdata;  // [1:0] status, [9:2] match_length, [10] is_word
	logic                           m_tuser;  // [0] op_echo

	trie_shadow shadow = new();

	// idle odds in percent per cycle for each side
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	// long receiver hold-off asked for by the stimulus, timed by the receiver
	int hold_request  = 0;
	int items_sent    = 0;
	int words_since_full = 0;

	// words known to be in the trie, for well-formed searches
	logic [4:0] dict_sym [DICT_SIZE][DICT_WORD];
	int         dict_len [DICT_SIZE];
	int         dict_n = 0;

	// key being sent, one symbol and one request kind per transaction
	logic [4:0] key_buf [KEY_MAX];
	logic       req_buf [KEY_MAX];
	int         key_len;

	trie_insert_search i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// offer one symbol, with random idle cycles in front; valid stays high after
	// the transaction so the next call can reuse it without a drop in the same step
	task automatic send_item(logic req, logic [4:0] sym, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, sym};
		s_tuser  <= req;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		shadow.note_symbol(req, sym, last);
		items_sent++;
	endtask

	task automatic send_text(logic req, string txt);
		for (int i = 0; i < txt.len(); i++)
			send_item(req, 5'(txt[i] - "a"), i == txt.len() - 1);
	endtask

	task automatic send_key();
		for (int i = 0; i < key_len; i++)
			send_item(req_buf[i], key_buf[i], i == key_len - 1);
	endtask

	// sender stops until every outstanding word has been answered
	task automatic drain();
		s_tvalid <= 1'b0;
		while (shadow.due_count() != 0) @(posedge clk);
	endtask

	// one random word: mostly well-formed inserts and searches, some noise
	task automatic play_word();
		int pick;
		int w;
		int n;
		int variant;
		bit narrow;
		bit fill;
		fill = (items_sent > ITEM_TARGET / 3) && (shadow.nodes_used < NODES);
		pick = $urandom_range(99);
		if (dict_n == 0) pick = 0;
		// while the pool is being filled most words are long fresh inserts
		if (fill && pick < 60) pick = 0;
		if (pick < 40) begin
			// fresh insert; a narrow alphabet half the time gives shared prefixes,
			// longer words while filling so the pool runs dry
			n      = $urandom_range(fill ? 60 : 12, 1);
			narrow = 1'($urandom_range(1));
			for (int i = 0; i < n; i++) begin
				key_buf[i] = narrow ? 5'($urandom_range(3)) : 5'($urandom_range(LETTERS - 1));
				req_buf[i] = tis_pkg::REQ_INSERT;
			end
			if (dict_n < DICT_SIZE) begin
				w = dict_n;
				dict_n++;
			end else begin
				w = $urandom_range(DICT_SIZE - 1);
			end
			dict_len[w] = (n < DICT_WORD) ? n : DICT_WORD;
			for (int i = 0; i < dict_len[w]; i++) dict_sym[w][i] = key_buf[i];
		end else if ((pick < 75) || ((pick >= 85) && (pick < 92))) begin
			// known word: exact, prefix or one letter longer
			w       = $urandom_range(dict_n - 1);
			n       = dict_len[w];
			variant = $urandom_range(3);
			for (int i = 0; i < n; i++) key_buf[i] = dict_sym[w][i];
			if (variant == 2) begin
				n = $urandom_range(n, 1);
			end else if (variant == 3) begin
				key_buf[n] = 5'($urandom_range(LETTERS - 1));
				n++;
			end
			for (int i = 0; i < n; i++)
				req_buf[i] = (pick < 75) ? tis_pkg::REQ_SEARCH : tis_pkg::REQ_INSERT;
		end else if (pick < 85) begin
			n = $urandom_range(6, 1);
			for (int i = 0; i < n; i++) begin
				key_buf[i] = 5'($urandom_range(LETTERS - 1));
				req_buf[i] = tis_pkg::REQ_SEARCH;
			end
		end else begin
			// noise: any symbol code, request kind mixed within the word
			n = $urandom_range(6, 1);
			for (int i = 0; i < n; i++) begin
				key_buf[i] = 5'($urandom_range(31));
				req_buf[i] = 1'($urandom_range(1));
			end
		end
		key_len = n;
		send_key();
		if (shadow.nodes_used >= NODES) words_since_full++;
	endtask

	// receiver: checks each result transaction and sets ready for the next cycle
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) shadow.check_outcome(m_tuser, m_tdata);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles in which neither side moves a transaction
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int phase_base;
		int phase_end;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 38;
		recv_idle_pct = 82;

		// directed words
		send_text(tis_pkg::REQ_SEARCH, "a");    // empty trie, miss at the root
		send_text(tis_pkg::REQ_INSERT, "a");
		send_text(tis_pkg::REQ_SEARCH, "a");    // found, word end
		send_text(tis_pkg::REQ_INSERT, "zb");   // top letter
		send_text(tis_pkg::REQ_SEARCH, "z");    // found, prefix only
		send_text(tis_pkg::REQ_SEARCH, "zy");   // missing link below the root
		// letter code beyond the alphabet in a search counts as a miss
		send_item(tis_pkg::REQ_SEARCH, 5'd0, 1'b0);
		send_item(tis_pkg::REQ_SEARCH, 5'd31, 1'b1);
		// beyond the alphabet in an insert is dropped, the word goes on
		send_item(tis_pkg::REQ_INSERT, 5'd26, 1'b0);
		send_item(tis_pkg::REQ_INSERT, 5'd2, 1'b1);
		send_text(tis_pkg::REQ_SEARCH, "c");
		// lone dropped letter that still ends the word
		send_item(tis_pkg::REQ_INSERT, 5'd30, 1'b1);
		// mixed kinds: search walks to a, insert hangs b below it
		send_item(tis_pkg::REQ_SEARCH, 5'd0, 1'b0);
		send_item(tis_pkg::REQ_INSERT, 5'd1, 1'b1);
		send_text(tis_pkg::REQ_SEARCH, "ab");
		// after a miss the rest is skipped, even an insert that ends the word
		send_item(tis_pkg::REQ_SEARCH, 5'd16, 1'b0);
		send_item(tis_pkg::REQ_INSERT, 5'd23, 1'b1);
		drain();

		phase_base = items_sent;
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 38;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 38;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (ph == 0) begin
				// overlong word: the match count must stop at its cap
				key_len = $urandom_range(280, 256);
				for (int i = 0; i < key_len; i++) begin
					key_buf[i] = 5'($urandom_range(LETTERS - 1));
					req_buf[i] = tis_pkg::REQ_INSERT;
				end
				send_key();
				// results back up behind a long receiver hold-off while the
				// search keeps being offered
				hold_request = 1500;
				for (int i = 0; i < key_len; i++) req_buf[i] = tis_pkg::REQ_SEARCH;
				send_key();
			end
			phase_end = phase_base + (ph + 1) * (ITEM_TARGET - phase_base) / 3;
			while (items_sent < phase_end || (ph == 2 && words_since_full < 16))
				play_word();
			drain();
		end

		repeat (16) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.due_count() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
